[rtl/dad_pkg.sv]
// Package for the date advance block: widths, sequencer states and calendar tables.
package dad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int NDAYS_W = 20;
  localparam int DOY_W   = 9;
  localparam int YEAR2_W = 15;
  localparam int C100_W  = 7;
  localparam int STEP_W  = 3;

  localparam int DAYS_BITS_DEF = 20;

  localparam logic [YEAR2_W-1:0] YEAR_MAX     = 15'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FIRST  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;
  localparam logic [DOY_W-1:0]   DAYS_LEAP    = 9'd366;
  localparam logic [DOY_W-1:0]   DAYS_COMMON  = 9'd365;
  localparam logic [C100_W-1:0]  C100_LAST    = 7'd99;
  localparam logic [STEP_W-1:0]  STEP_Q_HI    = 3'd6;
  localparam logic [STEP_W-1:0]  STEP_LAST    = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CLAMP,
    ST_FIRST,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } dad_state_t;

  // Subtrahends of the restoring year reduction: 400 * 2^k, then 200 and 100.
  function automatic logic [YEAR_W-1:0] reduce_sub(input logic [STEP_W-1:0] step);
    logic [YEAR_W-1:0] s;
    unique case (step)
      3'd0:    s = 14'd12800;
      3'd1:    s = 14'd6400;
      3'd2:    s = 14'd3200;
      3'd3:    s = 14'd1600;
      3'd4:    s = 14'd800;
      3'd5:    s = 14'd400;
      3'd6:    s = 14'd200;
      default: s = 14'd100;
    endcase
    return s;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before m in a common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] c;
    unique case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/dad_in_if.sv]
// Input channel of the date advance block: start date and day count.
interface dad_in_if;
  logic                         valid;
  logic                         ready;
  logic [dad_pkg::YEAR_W-1:0]   start_year;
  logic [dad_pkg::MONTH_W-1:0]  start_month;
  logic [dad_pkg::DAY_W-1:0]    start_day;
  logic [dad_pkg::NDAYS_W-1:0]  days_to_add;

  modport source(output valid, start_year, start_month, start_day, days_to_add,
                 input ready);
  modport sink(input valid, start_year, start_month, start_day, days_to_add,
               output ready);
endinterface

[rtl/dad_out_if.sv]
// Result channel of the date advance block: resulting date and overflow flag.
interface dad_out_if;
  logic                         valid;
  logic                         ready;
  logic [dad_pkg::YEAR_W-1:0]   result_year;
  logic [dad_pkg::MONTH_W-1:0]  result_month;
  logic [dad_pkg::DAY_W-1:0]    result_day;
  logic                         year_overflow;

  modport source(output valid, result_year, result_month, result_day, year_overflow,
                 input ready);
  modport sink(input valid, result_year, result_month, result_day, year_overflow,
               output ready);
endinterface

[rtl/date_add_days_top.sv]
// Date advance block: adds a day count to a Gregorian date with a shared subtractor.
//
// Usage: present a start date (year, month, day) and a day count on in_chan;
// the item is taken when valid and ready are both high. in_chan.ready is high
// only while the sequencer is idle, so one item is in work at a time. One
// result item per input item leaves on out_chan, held in an output register
// until the receiver takes it; the next input item may be taken while that
// result still waits.
// Each item runs through these steps in order: year reduction mod 400,
// clamp, first year, a year step per whole year crossed (stopping past
// year 9999), a month walk up to the result month, then the output load.
// A new item is taken only after the previous one has returned the
// sequencer to idle; the year loop through the shared subtract/compare
// unit takes the most steps for a long day count.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any pending result. When the receiver stalls, the finished result holds in
// the output register and a following item waits at the end of its work.
module date_add_days_top #(
  parameter int DAYS_BITS = dad_pkg::DAYS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dad_in_if.sink    in_chan,
  dad_out_if.source out_chan
);

  // Width of the shared subtractor: wide enough for the day count and a year.
  localparam int AW = (DAYS_BITS > dad_pkg::YEAR_W) ? DAYS_BITS : dad_pkg::YEAR_W;

  dad_pkg::dad_state_t state_r, state_nxt;

  logic [dad_pkg::YEAR2_W-1:0] y2_r, y2_nxt;       // current year of the walk
  logic [dad_pkg::YEAR_W-1:0]  rsd_r, rsd_nxt;     // year remainder during reduction
  logic [dad_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [1:0]                  q_r, q_nxt;         // (year mod 400) / 100
  logic [dad_pkg::C100_W-1:0]  c100_r, c100_nxt;   // year mod 100
  logic [dad_pkg::MONTH_W-1:0] mon_r, mon_nxt;
  logic [dad_pkg::DAY_W-1:0]   day_r, day_nxt;
  logic [dad_pkg::DOY_W-1:0]   doy_r, doy_nxt;
  logic [DAYS_BITS-1:0]        n_r, n_nxt;         // days still to place
  logic [dad_pkg::DOY_W-1:0]   off_r, off_nxt;     // day of the result, within its year then its month
  logic                        ovf_r, ovf_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [dad_pkg::YEAR_W-1:0]  out_year_r, out_year_nxt;
  logic [dad_pkg::MONTH_W-1:0] out_month_r, out_month_nxt;
  logic [dad_pkg::DAY_W-1:0]   out_day_r, out_day_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic                        leap;
  logic [dad_pkg::DOY_W-1:0]   ylen;
  logic [dad_pkg::DAY_W-1:0]   mlen;
  logic [31:0]                 days_ext;

  // Shared subtract/compare unit
  logic [AW-1:0]               alu_a, alu_b;
  logic [AW:0]                 alu_diff;
  logic                        alu_lt, alu_le;

  // Year advance with mod 100 / mod 400 tracking
  logic [dad_pkg::YEAR2_W-1:0] y2_inc;
  logic [dad_pkg::C100_W-1:0]  c100_inc;
  logic [1:0]                  q_inc;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign days_ext = {{(32 - dad_pkg::NDAYS_W){1'b0}}, in_chan.days_to_add};

  assign leap = ((y2_r[1:0] == 2'd0) && (c100_r != '0)) || ((c100_r == '0) && (q_r == 2'd0));
  assign ylen = leap ? dad_pkg::DAYS_LEAP : dad_pkg::DAYS_COMMON;
  assign mlen = dad_pkg::month_days(mon_r, leap);

  assign y2_inc   = y2_r + 1'b1;
  assign c100_inc = (c100_r == dad_pkg::C100_LAST) ? '0 : c100_r + 1'b1;
  assign q_inc    = (c100_r == dad_pkg::C100_LAST) ? q_r + 1'b1 : q_r;

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      dad_pkg::ST_REDUCE: begin
        alu_a = AW'(rsd_r);
        alu_b = AW'(dad_pkg::reduce_sub(step_r));
      end
      dad_pkg::ST_CLAMP: begin
        alu_a = AW'(day_r);
        alu_b = AW'(mlen);
      end
      dad_pkg::ST_FIRST: begin
        alu_a = AW'(n_r);
        alu_b = AW'(ylen - doy_r);
      end
      dad_pkg::ST_YEAR: begin
        alu_a = AW'(n_r);
        alu_b = AW'(ylen);
      end
      dad_pkg::ST_MONTH: begin
        alu_a = AW'(off_r);
        alu_b = AW'(mlen);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt   = alu_diff[AW];
  assign alu_le   = alu_lt || (alu_diff[AW-1:0] == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dad_pkg::ST_IDLE:   if (in_acc) state_nxt = dad_pkg::ST_REDUCE;
      dad_pkg::ST_REDUCE: if (step_r == dad_pkg::STEP_LAST) state_nxt = dad_pkg::ST_CLAMP;
      dad_pkg::ST_CLAMP:  state_nxt = dad_pkg::ST_FIRST;
      dad_pkg::ST_FIRST:  state_nxt = alu_le ? dad_pkg::ST_MONTH : dad_pkg::ST_YEAR;
      dad_pkg::ST_YEAR: begin
        if (y2_r > dad_pkg::YEAR_MAX) begin
          state_nxt = dad_pkg::ST_DONE;
        end else if (alu_le) begin
          state_nxt = dad_pkg::ST_MONTH;
        end
      end
      dad_pkg::ST_MONTH: begin
        if ((mon_r == dad_pkg::MONTH_LAST) || alu_le) state_nxt = dad_pkg::ST_DONE;
      end
      dad_pkg::ST_DONE:   if (out_free) state_nxt = dad_pkg::ST_IDLE;
      default:            state_nxt = dad_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    y2_nxt        = y2_r;
    rsd_nxt       = rsd_r;
    step_nxt      = step_r;
    q_nxt         = q_r;
    c100_nxt      = c100_r;
    mon_nxt       = mon_r;
    day_nxt       = day_r;
    doy_nxt       = doy_r;
    n_nxt         = n_r;
    off_nxt       = off_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_ovf_nxt   = out_ovf_r;
    unique case (state_r)
      dad_pkg::ST_IDLE: begin
        if (in_acc) begin
          // Load the item; clamp month and day-of-zero here, day length later.
          y2_nxt   = dad_pkg::YEAR2_W'(in_chan.start_year);
          rsd_nxt  = in_chan.start_year;
          step_nxt = '0;
          q_nxt    = '0;
          // A start year past the top of the range can only land past it.
          ovf_nxt  = (dad_pkg::YEAR2_W'(in_chan.start_year) > dad_pkg::YEAR_MAX);
          n_nxt    = days_ext[DAYS_BITS-1:0];
          if (in_chan.start_month < dad_pkg::MONTH_FIRST) begin
            mon_nxt = dad_pkg::MONTH_FIRST;
          end else if (in_chan.start_month > dad_pkg::MONTH_LAST) begin
            mon_nxt = dad_pkg::MONTH_LAST;
          end else begin
            mon_nxt = in_chan.start_month;
          end
          day_nxt = (in_chan.start_day < dad_pkg::DAY_FIRST) ? dad_pkg::DAY_FIRST
                                                            : in_chan.start_day;
        end
      end
      dad_pkg::ST_REDUCE: begin
        // Restoring reduction: year mod 400, then hundreds digit and mod 100.
        if (!alu_lt) rsd_nxt = alu_diff[dad_pkg::YEAR_W-1:0];
        if (step_r >= dad_pkg::STEP_Q_HI) q_nxt = {q_r[0], !alu_lt};
        if (step_r == dad_pkg::STEP_LAST) begin
          c100_nxt = alu_lt ? rsd_r[dad_pkg::C100_W-1:0]
                            : alu_diff[dad_pkg::C100_W-1:0];
        end
        step_nxt = step_r + 1'b1;
      end
      dad_pkg::ST_CLAMP: begin
        // Clamp the day to its month, then form the day of year.
        if (!alu_le) day_nxt = mlen;
        doy_nxt = dad_pkg::DOY_W'(alu_le ? day_r : mlen) + dad_pkg::days_before(mon_r)
                + dad_pkg::DOY_W'(leap && (mon_r > dad_pkg::MONTH_FEB));
      end
      dad_pkg::ST_FIRST: begin
        if (alu_le) begin
          off_nxt = doy_r + n_r[dad_pkg::DOY_W-1:0];
          mon_nxt = dad_pkg::MONTH_FIRST;
        end else begin
          n_nxt    = alu_diff[DAYS_BITS-1:0];
          y2_nxt   = y2_inc;
          c100_nxt = c100_inc;
          q_nxt    = q_inc;
        end
      end
      dad_pkg::ST_YEAR: begin
        if (y2_r > dad_pkg::YEAR_MAX) begin
          ovf_nxt = 1'b1;
        end else if (alu_le) begin
          off_nxt = n_r[dad_pkg::DOY_W-1:0];
          mon_nxt = dad_pkg::MONTH_FIRST;
        end else begin
          n_nxt    = alu_diff[DAYS_BITS-1:0];
          y2_nxt   = y2_inc;
          c100_nxt = c100_inc;
          q_nxt    = q_inc;
        end
      end
      dad_pkg::ST_MONTH: begin
        if (!((mon_r == dad_pkg::MONTH_LAST) || alu_le)) begin
          off_nxt = alu_diff[dad_pkg::DOY_W-1:0];
          mon_nxt = mon_r + 1'b1;
        end
      end
      dad_pkg::ST_DONE: begin
        // Hold until the output register is free, then load it.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (ovf_r) begin
            out_year_nxt  = dad_pkg::YEAR_MAX[dad_pkg::YEAR_W-1:0];
            out_month_nxt = dad_pkg::MONTH_LAST;
            out_day_nxt   = dad_pkg::DAY_LAST_DEC;
          end else begin
            out_year_nxt  = y2_r[dad_pkg::YEAR_W-1:0];
            out_month_nxt = mon_r;
            out_day_nxt   = off_r[dad_pkg::DAY_W-1:0];
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_chan.ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dad_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y2_r        <= y2_nxt;
    rsd_r       <= rsd_nxt;
    step_r      <= step_nxt;
    q_r         <= q_nxt;
    c100_r      <= c100_nxt;
    mon_r       <= mon_nxt;
    day_r       <= day_nxt;
    doy_r       <= doy_nxt;
    n_r         <= n_nxt;
    off_r       <= off_nxt;
    ovf_r       <= ovf_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_chan.ready          = (state_r == dad_pkg::ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_year   = out_year_r;
  assign out_chan.result_month  = out_month_r;
  assign out_chan.result_day    = out_day_r;
  assign out_chan.year_overflow = out_ovf_r;

endmodule

[rtl/dad_checker.sv]
// Port-level checker for the date advance block, bound to the top level.
module dad_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dad_pkg::YEAR_W-1:0]  out_year,
  input logic [dad_pkg::MONTH_W-1:0] out_month,
  input logic [dad_pkg::DAY_W-1:0]   out_day,
  input logic                        out_ovf
);

  // A pending result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // One item at a time: input closes after an item is taken.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after taking an item");

  // Overflow saturates the date to the last day of the last year.
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ovf |->
      (out_year == 14'd9999) && (out_month == 4'd12) && (out_day == 5'd31))
    else $error("overflow result not saturated");

  // Results have a year up to 9999, a month in 1 to 12 and a day of at least 1.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year <= 14'd9999) && (out_month >= 4'd1) &&
                  (out_month <= 4'd12) && (out_day >= 5'd1))
    else $error("result date out of range");

  // Reset clears any pending result.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind date_add_days_top dad_checker u_dad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_year  (out_chan.result_year),
  .out_month (out_chan.result_month),
  .out_day   (out_chan.result_day),
  .out_ovf   (out_chan.year_overflow)
);
